// ===== hw/rtl/pffra_pkg.sv =====
// shared types and codes for the priority first-fit resource allocator
// no dependencies; used by pffra_first_fit and priority_first_fit_resource_allocator
package pffra_pkg;

    localparam int UNIT_PORT_W = 8;   // width of the units and free_after ports
    localparam int SLOT_PORT_W = 2;   // width of the slot and granted_slot ports
    localparam int CNT_W       = 32;  // outcome counters
    localparam int CFG_IDX_W   = 2;   // four capacity registers

    typedef enum logic
    {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        OUTCOME_ASSIGNED = 3'd0,
        OUTCOME_REJECTED = 3'd1,
        OUTCOME_BLOCKED  = 3'd2,
        OUTCOME_WAITING  = 3'd3,
        OUTCOME_RELEASED = 3'd4
    } outcome_t;

    // allocate decision handed from the first-fit unit to the top level
    typedef struct packed
    {
        outcome_t outcome;
    } decision_t;

endpackage

// ===== hw/rtl/priority_first_fit_resource_allocator.sv =====
// priority first-fit resource allocator, top level
// holds slot capacities, free units and outcome counters
// depends on pffra_pkg and pffra_first_fit
//
// usage
//   config port: cfg_wr_en/cfg_addr/cfg_wdata write capacity_slotN; the write also
//   reloads that slot's free units. write only while the block is idle.
//   input channel (in_valid/in_ready): one transaction is an allocate or release
//   item (opcode, units, slot). output channel (out_valid/out_ready): one result
//   transaction per item (outcome, granted_slot, free_after and the three totals).
// throughput
//   an accepted item is held in the input register, where the first-fit
//   compare and priority encode plus one add or subtract resolve it; the result
//   register takes it once it is empty or being read out. one item per cycle
//   sustained while out_ready is high.
// stall behavior
//   with out_ready low the result register holds; the input register can still
//   take one more transaction, after which in_ready drops until out_ready returns.
// reset
//   rst_n clears capacities, free units, counters and both valid flags.
module priority_first_fit_resource_allocator
#(
    parameter int NUM_SLOTS = 4,
    parameter int UNIT_BITS = 8
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    cfg_wr_en,
    input  logic [pffra_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [UNIT_BITS-1:0]                    cfg_wdata,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    opcode,
    input  logic [pffra_pkg::UNIT_PORT_W-1:0]       units,
    input  logic [pffra_pkg::SLOT_PORT_W-1:0]       slot,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [2:0]                              outcome,
    output logic [pffra_pkg::SLOT_PORT_W-1:0]       granted_slot,
    output logic [pffra_pkg::UNIT_PORT_W-1:0]       free_after,
    output logic [pffra_pkg::CNT_W-1:0]             rejected_total,
    output logic [pffra_pkg::CNT_W-1:0]             blocked_total,
    output logic [pffra_pkg::CNT_W-1:0]             waited_total
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int UP_W  = pffra_pkg::UNIT_PORT_W;
    localparam logic [3:0] NUM_SLOTS_L = 4'(NUM_SLOTS);

    // slot state
    logic [NUM_SLOTS-1:0][UNIT_BITS-1:0] cap_reg;
    logic [NUM_SLOTS-1:0][UNIT_BITS-1:0] free_reg;
    logic [NUM_SLOTS-1:0][UNIT_BITS-1:0] free_next;

    logic [pffra_pkg::CNT_W-1:0] rej_cnt_reg,  rej_cnt_next;
    logic [pffra_pkg::CNT_W-1:0] blk_cnt_reg,  blk_cnt_next;
    logic [pffra_pkg::CNT_W-1:0] wait_cnt_reg, wait_cnt_next;

    // input register
    logic                            s1_valid_reg;
    pffra_pkg::opcode_t              s1_opcode_reg;
    logic [UNIT_BITS-1:0]            s1_units_reg;
    logic [pffra_pkg::SLOT_PORT_W-1:0] s1_slot_reg;

    // result register
    logic                            out_valid_reg;
    pffra_pkg::outcome_t             out_outcome_reg,  out_outcome_next;
    logic [pffra_pkg::SLOT_PORT_W-1:0] out_slot_reg,   out_slot_next;
    logic [UP_W-1:0]                 out_free_reg,     out_free_next;

    logic s1_advance;
    logic in_fire;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // units port masked to the internal unit width
    logic [UNIT_BITS+UP_W-1:0] units_wide;
    assign units_wide = {{UNIT_BITS{1'b0}}, units};

    // first-fit search on the held item
    pffra_pkg::decision_t decision;
    logic [IDX_W-1:0]     hit_idx;

    pffra_first_fit
    #(
        .NUM_SLOTS (NUM_SLOTS),
        .UNIT_BITS (UNIT_BITS),
        .IDX_W     (IDX_W)
    )
    u_first_fit
    (
        .units      (s1_units_reg),
        .free_units (free_reg),
        .capacity   (cap_reg),
        .decision   (decision),
        .hit_idx    (hit_idx)
    );

    // release path: slot index check and saturating add
    logic [3:0]           rel_slot_ext;
    logic                 rel_slot_ok;
    logic [IDX_W-1:0]     rel_idx;
    logic [UNIT_BITS:0]   rel_sum;
    logic [UNIT_BITS-1:0] rel_free;
    logic [UNIT_BITS-1:0] alloc_free;
    logic [3:0]           hit_ext;

    assign rel_slot_ext = {2'b00, s1_slot_reg};
    assign rel_slot_ok  = (rel_slot_ext < NUM_SLOTS_L);
    assign rel_idx      = rel_slot_ext[IDX_W-1:0];
    assign rel_sum      = {1'b0, free_reg[rel_idx]} + {1'b0, s1_units_reg};
    assign rel_free     = (rel_sum > {1'b0, cap_reg[rel_idx]}) ? cap_reg[rel_idx]
                                                               : rel_sum[UNIT_BITS-1:0];
    assign alloc_free   = free_reg[hit_idx] - s1_units_reg;
    assign hit_ext      = 4'(hit_idx);

    // capacity write decode, indexes past the last slot are dropped
    logic [3:0]       cfg_addr_ext;
    logic             cfg_hit;
    logic [IDX_W-1:0] cfg_idx;

    assign cfg_addr_ext = {2'b00, cfg_addr};
    assign cfg_hit      = cfg_wr_en && (cfg_addr_ext < NUM_SLOTS_L);
    assign cfg_idx      = cfg_addr_ext[IDX_W-1:0];

    logic [UNIT_BITS+UP_W-1:0] fa_wide;
    logic [UNIT_BITS-1:0]      fa_value;
    assign fa_wide = {{UP_W{1'b0}}, fa_value};

    always_comb
    begin
        free_next        = free_reg;
        rej_cnt_next     = rej_cnt_reg;
        blk_cnt_next     = blk_cnt_reg;
        wait_cnt_next    = wait_cnt_reg;
        out_outcome_next = decision.outcome;
        out_slot_next    = '0;
        fa_value         = '0;

        if (s1_opcode_reg == pffra_pkg::OP_RELEASE)
        begin
            out_outcome_next = pffra_pkg::OUTCOME_RELEASED;
            out_slot_next    = s1_slot_reg;
            if (rel_slot_ok)
            begin
                fa_value = rel_free;
                if (s1_advance)
                begin
                    free_next[rel_idx] = rel_free;
                end
            end
        end
        else
        begin
            unique case (decision.outcome)
                pffra_pkg::OUTCOME_ASSIGNED:
                begin
                    out_slot_next = hit_ext[pffra_pkg::SLOT_PORT_W-1:0];
                    fa_value      = alloc_free;
                    if (s1_advance)
                    begin
                        free_next[hit_idx] = alloc_free;
                    end
                end
                pffra_pkg::OUTCOME_REJECTED:
                begin
                    if (s1_advance)
                    begin
                        rej_cnt_next = rej_cnt_reg + 1'b1;
                    end
                end
                pffra_pkg::OUTCOME_BLOCKED:
                begin
                    if (s1_advance)
                    begin
                        blk_cnt_next = blk_cnt_reg + 1'b1;
                    end
                end
                pffra_pkg::OUTCOME_WAITING:
                begin
                    if (s1_advance)
                    begin
                        wait_cnt_next = wait_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    out_slot_next = '0;
                end
            endcase
        end

        out_free_next = fa_wide[UP_W-1:0];

        // capacity write reloads the slot's free units
        if (cfg_hit)
        begin
            free_next[cfg_idx] = cfg_wdata;
        end
    end

    // slot state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= '0;
            free_reg     <= '0;
            rej_cnt_reg  <= '0;
            blk_cnt_reg  <= '0;
            wait_cnt_reg <= '0;
        end
        else
        begin
            free_reg     <= free_next;
            rej_cnt_reg  <= rej_cnt_next;
            blk_cnt_reg  <= blk_cnt_next;
            wait_cnt_reg <= wait_cnt_next;
            if (cfg_hit)
            begin
                cap_reg[cfg_idx] <= cfg_wdata;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_opcode_reg <= pffra_pkg::opcode_t'(opcode);
            s1_units_reg  <= units_wide[UNIT_BITS-1:0];
            s1_slot_reg   <= slot;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_outcome_reg <= out_outcome_next;
            out_slot_reg    <= out_slot_next;
            out_free_reg    <= out_free_next;
        end
    end

    // counters only move when a result enters the result register, so they
    // stay aligned with the held result
    assign out_valid      = out_valid_reg;
    assign outcome        = out_outcome_reg;
    assign granted_slot   = out_slot_reg;
    assign free_after     = out_free_reg;
    assign rejected_total = rej_cnt_reg;
    assign blocked_total  = blk_cnt_reg;
    assign waited_total   = wait_cnt_reg;

endmodule

// ===== hw/rtl/pffra_first_fit.sv =====
// first-fit search and unplaced-request classification for one allocate
// depends on pffra_pkg
module pffra_first_fit
#(
    parameter int NUM_SLOTS = 4,
    parameter int UNIT_BITS = 8,
    parameter int IDX_W     = 2
)
(
    input  logic [UNIT_BITS-1:0]                 units,
    input  logic [NUM_SLOTS-1:0][UNIT_BITS-1:0]  free_units,
    input  logic [NUM_SLOTS-1:0][UNIT_BITS-1:0]  capacity,
    output pffra_pkg::decision_t                 decision,
    output logic [IDX_W-1:0]                     hit_idx
);

    logic [NUM_SLOTS-1:0] fits;
    logic [NUM_SLOTS-1:0] too_small;
    logic [NUM_SLOTS-1:0] idle;

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            fits[i]      = (units <= free_units[i]);
            too_small[i] = (units > capacity[i]);
            idle[i]      = (capacity[i] == free_units[i]);
        end
    end

    // lowest index wins: scan from the top down
    always_comb
    begin
        hit_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (fits[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        priority if (|fits)
        begin
            decision.outcome = pffra_pkg::OUTCOME_ASSIGNED;
        end
        else if (&too_small)
        begin
            decision.outcome = pffra_pkg::OUTCOME_REJECTED;
        end
        else if (!(|idle))
        begin
            decision.outcome = pffra_pkg::OUTCOME_BLOCKED;
        end
        else
        begin
            decision.outcome = pffra_pkg::OUTCOME_WAITING;
        end
    end

endmodule

// ===== tb/priority_first_fit_resource_allocator_tb.sv =====
// self-checking testbench for priority_first_fit_resource_allocator
// depends on pffra_pkg and the allocator rtl; the scoreboard class holds its own slot model
module priority_first_fit_resource_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT     = 4;
    localparam int UNIT_W         = 8;
    localparam int PHASE_ITEMS    = 100;   // transactions per capacity setting
    localparam int RANDOM_PHASES  = 13;    // about 1300 random transactions in total
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction on any channel
    localparam int MAX_IDLE       = 15;

    // one expected result transaction
    typedef struct
    {
        pffra_pkg::outcome_t outcome;
        logic [1:0]          granted_slot;
        logic [UNIT_W-1:0]   free_after;
        logic [31:0]         rejected_total;
        logic [31:0]         blocked_total;
        logic [31:0]         waited_total;
    } alloc_result_t;

    // slot model plus the queue of results still owed by the block
    class allocator_scoreboard;
        logic [UNIT_W-1:0] capacity [SLOT_COUNT];
        logic [UNIT_W-1:0] free_units [SLOT_COUNT];
        logic [31:0]       rej_tally;
        logic [31:0]       blk_tally;
        logic [31:0]       wait_tally;
        alloc_result_t     owed_results [$];
        int unsigned       mismatches;
        int unsigned       outcome_seen [5];

        function new();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                capacity[i]   = '0;
                free_units[i] = '0;
            end
            rej_tally  = '0;
            blk_tally  = '0;
            wait_tally = '0;
            mismatches = 0;
            for (int i = 0; i < 5; i++)
            begin
                outcome_seen[i] = 0;
            end
        endfunction

        // a capacity write also refills the slot
        function void load_capacity(int idx, logic [UNIT_W-1:0] value);
            capacity[idx]   = value;
            free_units[idx] = value;
        endfunction

        function int unsigned outstanding();
            return owed_results.size();
        endfunction

        // resolve one accepted transaction and queue its result
        function void note_request(pffra_pkg::opcode_t op, logic [UNIT_W-1:0] amount,
                                   logic [1:0] target);
            alloc_result_t r;
            int            fit_slot;
            int            too_small;
            bit            any_idle;
            logic [UNIT_W:0] sum;
            r.outcome      = pffra_pkg::OUTCOME_ASSIGNED;
            r.granted_slot = '0;
            r.free_after   = '0;
            if (op == pffra_pkg::OP_RELEASE)
            begin
                // release saturates at the slot capacity
                r.outcome      = pffra_pkg::OUTCOME_RELEASED;
                r.granted_slot = target;
                sum = {1'b0, free_units[target]} + {1'b0, amount};
                if (sum > {1'b0, capacity[target]})
                begin
                    sum = {1'b0, capacity[target]};
                end
                free_units[target] = sum[UNIT_W-1:0];
                r.free_after       = free_units[target];
            end
            else
            begin
                fit_slot  = -1;
                too_small = 0;
                any_idle  = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (fit_slot < 0)
                    begin
                        if (amount <= free_units[i])
                        begin
                            fit_slot = i;
                        end
                        else
                        begin
                            if (amount > capacity[i])
                            begin
                                too_small++;
                            end
                            if (capacity[i] == free_units[i])
                            begin
                                any_idle = 1'b1;
                            end
                        end
                    end
                end
                if (fit_slot >= 0)
                begin
                    free_units[fit_slot] = free_units[fit_slot] - amount;
                    r.granted_slot       = fit_slot[1:0];
                    r.free_after         = free_units[fit_slot];
                end
                else if (too_small == SLOT_COUNT)
                begin
                    r.outcome = pffra_pkg::OUTCOME_REJECTED;
                    rej_tally = rej_tally + 32'd1;
                end
                else if (!any_idle)
                begin
                    r.outcome = pffra_pkg::OUTCOME_BLOCKED;
                    blk_tally = blk_tally + 32'd1;
                end
                else
                begin
                    r.outcome  = pffra_pkg::OUTCOME_WAITING;
                    wait_tally = wait_tally + 32'd1;
                end
            end
            r.rejected_total = rej_tally;
            r.blocked_total  = blk_tally;
            r.waited_total   = wait_tally;
            owed_results.insert(owed_results.size(), r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_result(logic [2:0] oc, logic [1:0] gs, logic [UNIT_W-1:0] fa,
                                   logic [31:0] rt, logic [31:0] bt, logic [31:0] wt);
            alloc_result_t r;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                $error("result transaction with no request outstanding, outcome %0d", oc);
                return;
            end
            r = owed_results.pop_front();
            outcome_seen[r.outcome]++;
            compare_field("outcome", 32'(r.outcome), 32'(oc));
            compare_field("granted_slot", 32'(r.granted_slot), 32'(gs));
            compare_field("free_after", 32'(r.free_after), 32'(fa));
            compare_field("rejected_total", r.rejected_total, rt);
            compare_field("blocked_total", r.blocked_total, bt);
            compare_field("waited_total", r.waited_total, wt);
        endfunction
    endclass

    // clock, reset and block ports; the driven ones are known from time zero
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [pffra_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [UNIT_W-1:0] cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              opcode    = 1'b0;
    logic [pffra_pkg::UNIT_PORT_W-1:0] units = '0;
    logic [pffra_pkg::SLOT_PORT_W-1:0] slot  = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        outcome;
    logic [pffra_pkg::SLOT_PORT_W-1:0] granted_slot;
    logic [pffra_pkg::UNIT_PORT_W-1:0] free_after;
    logic [pffra_pkg::CNT_W-1:0]  rejected_total;
    logic [pffra_pkg::CNT_W-1:0]  blocked_total;
    logic [pffra_pkg::CNT_W-1:0]  waited_total;

    allocator_scoreboard sb;

    // idle behavior of both sides, redrawn for each random phase
    bit sender_gaps   = 1'b0;
    bit receiver_gaps = 1'b0;

    logic [UNIT_W-1:0] cap_now [SLOT_COUNT];  // capacities currently programmed
    int unsigned       settings_used = 0;
    int unsigned       idle_cycles   = 0;

    priority_first_fit_resource_allocator
    #(
        .NUM_SLOTS (SLOT_COUNT),
        .UNIT_BITS (UNIT_W)
    )
    dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .units          (units),
        .slot           (slot),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .outcome        (outcome),
        .granted_slot   (granted_slot),
        .free_after     (free_after),
        .rejected_total (rejected_total),
        .blocked_total  (blocked_total),
        .waited_total   (waited_total)
    );

    always #4 clk = ~clk;

    // watchdog: ends the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("[priority_first_fit_resource_allocator] ERROR");
                    $finish;
                end
            end
        end
    end

    // offer one request transaction; starts and ends at a falling edge
    task automatic send_item(pffra_pkg::opcode_t op, logic [UNIT_W-1:0] amount,
                             logic [1:0] target);
        int unsigned gap;
        gap = sender_gaps ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        units    <= amount;
        slot     <= target;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_request(op, amount, target);
        @(negedge clk);
    endtask

    // hold the sender until every owed result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // program all four capacities from cap_now while the block is idle
    task automatic apply_capacities();
        drain();
        repeat (4) @(negedge clk);  // let the last result leave the pipeline
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= i[pffra_pkg::CFG_IDX_W-1:0];
            cfg_wdata <= cap_now[i];
            sb.load_capacity(i, cap_now[i]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic set_caps(logic [UNIT_W-1:0] c0, logic [UNIT_W-1:0] c1,
                            logic [UNIT_W-1:0] c2, logic [UNIT_W-1:0] c3);
        cap_now[0] = c0;
        cap_now[1] = c1;
        cap_now[2] = c2;
        cap_now[3] = c3;
        apply_capacities();
    endtask

    // mostly requests sized to the programmed slots, some out-of-range noise
    task automatic random_item();
        int unsigned       pick;
        logic [1:0]        target;
        logic [UNIT_W-1:0] amount;
        pick   = $urandom_range(0, 99);
        target = 2'($urandom_range(0, SLOT_COUNT - 1));
        if (pick < 50)
        begin
            amount = UNIT_W'($urandom_range(0, cap_now[target]));
            send_item(pffra_pkg::OP_ALLOC, amount, 2'($urandom_range(0, 3)));
        end
        else if (pick < 60)
        begin
            amount = UNIT_W'($urandom_range(0, 255));
            send_item(pffra_pkg::OP_ALLOC, amount, 2'($urandom_range(0, 3)));
        end
        else if (pick < 90)
        begin
            amount = UNIT_W'($urandom_range(0, cap_now[target]));
            send_item(pffra_pkg::OP_RELEASE, amount, target);
        end
        else
        begin
            amount = UNIT_W'($urandom_range(0, 255));
            send_item(pffra_pkg::OP_RELEASE, amount, target);
        end
    endtask

    // receiver: random stall before each result, then take it and check
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = receiver_gaps ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            sb.check_result(outcome, granted_slot, free_after,
                            rejected_total, blocked_total, waited_total);
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        logic [UNIT_W-1:0] prev;
        sb = new();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            cap_now[i] = '0;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // all capacities still zero after reset
        send_item(pffra_pkg::OP_ALLOC, 8'd0, 2'd3);      // zero-unit allocate lands on slot 0
        send_item(pffra_pkg::OP_ALLOC, 8'd1, 2'd0);      // larger than every slot, rejected
        send_item(pffra_pkg::OP_RELEASE, 8'd255, 2'd2);  // clamps at zero capacity

        // walk through every allocate outcome with small slots
        set_caps(8'd10, 8'd20, 8'd30, 8'd40);
        send_item(pffra_pkg::OP_ALLOC, 8'd10, 2'd1);     // fills slot 0
        send_item(pffra_pkg::OP_ALLOC, 8'd25, 2'd2);     // skips to slot 2
        send_item(pffra_pkg::OP_ALLOC, 8'd35, 2'd0);     // slot 3
        send_item(pffra_pkg::OP_ALLOC, 8'd30, 2'd3);     // no fit, slot 1 still idle: waiting
        send_item(pffra_pkg::OP_ALLOC, 8'd20, 2'd0);     // slot 1
        send_item(pffra_pkg::OP_ALLOC, 8'd6, 2'd1);      // no fit, nothing idle: blocked
        send_item(pffra_pkg::OP_ALLOC, 8'd41, 2'd2);     // exceeds every capacity: rejected
        send_item(pffra_pkg::OP_RELEASE, 8'd255, 2'd0);  // overflow saturates at 10
        send_item(pffra_pkg::OP_RELEASE, 8'd0, 2'd3);
        drain();                                         // sender waits for every owed result
        send_item(pffra_pkg::OP_ALLOC, 8'd0, 2'd0);      // zero units, slot 0 unchanged
        send_item(pffra_pkg::OP_RELEASE, 8'd7, 2'd1);
        send_item(pffra_pkg::OP_RELEASE, 8'd25, 2'd2);

        // widest slots
        set_caps(8'd255, 8'd255, 8'd255, 8'd255);
        send_item(pffra_pkg::OP_ALLOC, 8'd255, 2'd0);
        send_item(pffra_pkg::OP_ALLOC, 8'd255, 2'd3);
        send_item(pffra_pkg::OP_RELEASE, 8'd255, 2'd0);

        // random phases, each with its own capacity shape and idle behavior
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            unique case (p % 5)
                0:
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        cap_now[i] = UNIT_W'($urandom_range(0, 255));
                    end
                end
                1:
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        cap_now[i] = UNIT_W'($urandom_range(1, 15));
                    end
                end
                2:
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        cap_now[i] = 8'd255;
                    end
                end
                3:
                begin
                    // a zero-capacity slot is always idle, so misses that are not rejected turn into waits
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        cap_now[i] = UNIT_W'($urandom_range(0, 60));
                    end
                    cap_now[$urandom_range(0, SLOT_COUNT - 1)] = 8'd0;
                end
                default:
                begin
                    // descending sizes, as a priority sort would leave them
                    prev = 8'd255;
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        cap_now[i] = UNIT_W'($urandom_range(0, prev));
                        prev       = cap_now[i];
                    end
                end
            endcase
            apply_capacities();
            sender_gaps   = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            receiver_gaps = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 && p % 2 == 1)
                begin
                    drain();
                end
                random_item();
            end
        end

        // wait out the tail
        drain();
        repeat (8) @(negedge clk);
        $display("covered directed corners plus %0d random transactions over %0d capacity settings",
                 RANDOM_PHASES * PHASE_ITEMS, settings_used);
        $display("outcomes seen: assigned %0d, rejected %0d, blocked %0d, waiting %0d, released %0d",
                 sb.outcome_seen[pffra_pkg::OUTCOME_ASSIGNED],
                 sb.outcome_seen[pffra_pkg::OUTCOME_REJECTED],
                 sb.outcome_seen[pffra_pkg::OUTCOME_BLOCKED],
                 sb.outcome_seen[pffra_pkg::OUTCOME_WAITING],
                 sb.outcome_seen[pffra_pkg::OUTCOME_RELEASED]);
        if (sb.mismatches == 0)
        begin
            $display("[priority_first_fit_resource_allocator] OK");
        end
        else
        begin
            $display("[priority_first_fit_resource_allocator] ERROR");
        end
        $finish;
    end

endmodule
